// File: src/ubx_fp_pkg.sv
// Shared types and constants for the frame parser.
`timescale 1ns / 1ps
`default_nettype none
package ubx_fp_pkg;

  localparam int UFP_BUF_DEPTH = 256;

  localparam logic [7:0] UFP_SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0] UFP_SYNC_SECOND_RST = 8'd98;

  localparam logic [0:0] CFG_SYNC_FIRST  = 1'd0;
  localparam logic [0:0] CFG_SYNC_SECOND = 1'd1;

  localparam logic [0:0] KIND_RX   = 1'b0;
  localparam logic [0:0] KIND_READ = 1'b1;

  localparam logic [1:0] RK_GOOD     = 2'd0;
  localparam logic [1:0] RK_BADSUM   = 2'd1;
  localparam logic [1:0] RK_OVERSIZE = 2'd2;
  localparam logic [1:0] RK_READ     = 2'd3;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] class_byte;
    logic [7:0] msg_ident;
    logic [8:0] frame_length;
    logic [7:0] read_data;
  } ufp_res_t;

endpackage
`default_nettype wire

// File: src/ubx_fp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ubx_fp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/ubx_fp_parser.sv
// Frame parser state machine, checksum and payload store access.
`timescale 1ns / 1ps
`default_nettype none
module ubx_fp_parser #(
  parameter int BUF_DEPTH = ubx_fp_pkg::UFP_BUF_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         acc,
  input  wire logic                         kind,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic [7:0]                   read_index,
  input  wire logic [7:0]                   sync_first,
  input  wire logic [7:0]                   sync_second,
  output logic                              ram_we,
  output logic [$clog2(BUF_DEPTH)-1:0]      ram_waddr,
  output logic [7:0]                        ram_wdata,
  output logic [$clog2(BUF_DEPTH)-1:0]      ram_raddr,
  input  wire logic [7:0]                   ram_rdata,
  output logic                              res_valid,
  output ubx_fp_pkg::ufp_res_t              res
);
  import ubx_fp_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int LW = $clog2(BUF_DEPTH + 1);
  localparam int IW = (AW > 8) ? AW : 8;
  localparam logic [IW:0] IDX_LIMIT = (IW+1)'(BUF_DEPTH);

  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_IDENT   = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CK_A    = 4'd7;
  localparam logic [3:0] PH_CK_B    = 4'd8;

  logic [3:0]    phase_r, phase_nxt;
  logic [7:0]    class_r, class_nxt;
  logic [7:0]    ident_r, ident_nxt;
  logic [7:0]    len_lo_r, len_lo_nxt;
  logic [LW-1:0] exp_len_r, exp_len_nxt;
  logic [LW-1:0] count_r, count_nxt;
  logic [7:0]    sum_a_r, sum_a_nxt;
  logic [7:0]    sum_b_r, sum_b_nxt;

  logic          p_valid_r, p_valid_nxt;
  logic          p_rd_ok_r, p_rd_ok_nxt;
  ufp_res_t      p_res_r, p_res_nxt;

  logic [7:0]    add_a;
  logic [15:0]   full_len;
  logic [15:0]   exp_len16;
  logic [LW-1:0] count_inc;
  logic [IW-1:0] idx_ext;

  assign add_a     = sum_a_r + rx_byte;
  assign full_len  = {rx_byte, len_lo_r};
  assign exp_len16 = 16'(exp_len_r);
  assign count_inc = count_r + LW'(1);
  assign idx_ext   = IW'(read_index);

  assign ram_raddr = idx_ext[AW-1:0];
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = rx_byte;
  assign ram_we    = acc && (kind == KIND_RX) && (phase_r == PH_PAYLOAD);

  always_comb begin
    phase_nxt   = phase_r;
    class_nxt   = class_r;
    ident_nxt   = ident_r;
    len_lo_nxt  = len_lo_r;
    exp_len_nxt = exp_len_r;
    count_nxt   = count_r;
    sum_a_nxt   = sum_a_r;
    sum_b_nxt   = sum_b_r;
    p_valid_nxt = 1'b0;
    p_rd_ok_nxt = 1'b0;
    p_res_nxt   = '0;
    p_res_nxt.class_byte   = class_r;
    p_res_nxt.msg_ident    = ident_r;
    p_res_nxt.frame_length = exp_len16[8:0];
    if (acc) begin
      if (kind == KIND_READ) begin
        p_valid_nxt           = 1'b1;
        p_rd_ok_nxt           = {1'b0, idx_ext} < IDX_LIMIT;
        p_res_nxt             = '0;
        p_res_nxt.result_kind = RK_READ;
      end else begin
        case (phase_r)
          PH_SYNC2: begin
            if (rx_byte == sync_second) begin
              phase_nxt = PH_CLASS;
            end else if (rx_byte == sync_first) begin
              phase_nxt = PH_SYNC2;
            end else begin
              phase_nxt = PH_SYNC1;
            end
          end
          PH_CLASS: begin
            class_nxt = rx_byte;
            sum_a_nxt = rx_byte;
            sum_b_nxt = rx_byte;
            phase_nxt = PH_IDENT;
          end
          PH_IDENT: begin
            ident_nxt = rx_byte;
            sum_a_nxt = add_a;
            sum_b_nxt = sum_b_r + add_a;
            phase_nxt = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_lo_nxt = rx_byte;
            sum_a_nxt  = add_a;
            sum_b_nxt  = sum_b_r + add_a;
            phase_nxt  = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            sum_a_nxt = add_a;
            sum_b_nxt = sum_b_r + add_a;
            count_nxt = '0;
            if (full_len > 16'(BUF_DEPTH)) begin
              exp_len_nxt            = '0;
              phase_nxt              = PH_SYNC1;
              p_valid_nxt            = 1'b1;
              p_res_nxt.result_kind  = RK_OVERSIZE;
              p_res_nxt.frame_length = '0;
            end else begin
              exp_len_nxt = full_len[LW-1:0];
              phase_nxt   = (full_len == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            sum_a_nxt = add_a;
            sum_b_nxt = sum_b_r + add_a;
            count_nxt = count_inc;
            if (count_inc >= exp_len_r) begin
              phase_nxt = PH_CK_A;
            end
          end
          PH_CK_A: begin
            if (rx_byte != sum_a_r) begin
              phase_nxt             = PH_SYNC1;
              p_valid_nxt           = 1'b1;
              p_res_nxt.result_kind = RK_BADSUM;
            end else begin
              phase_nxt = PH_CK_B;
            end
          end
          PH_CK_B: begin
            phase_nxt             = PH_SYNC1;
            p_valid_nxt           = 1'b1;
            p_res_nxt.result_kind = (rx_byte == sum_b_r) ? RK_GOOD : RK_BADSUM;
          end
          default: begin
            phase_nxt = (rx_byte == sync_first) ? PH_SYNC2 : PH_SYNC1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SYNC1;
      class_r   <= '0;
      ident_r   <= '0;
      len_lo_r  <= '0;
      exp_len_r <= '0;
      count_r   <= '0;
      sum_a_r   <= '0;
      sum_b_r   <= '0;
      p_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      class_r   <= class_nxt;
      ident_r   <= ident_nxt;
      len_lo_r  <= len_lo_nxt;
      exp_len_r <= exp_len_nxt;
      count_r   <= count_nxt;
      sum_a_r   <= sum_a_nxt;
      sum_b_r   <= sum_b_nxt;
      p_valid_r <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_rd_ok_r <= p_rd_ok_nxt;
    p_res_r   <= p_res_nxt;
  end

  // store read data comes from the registered RAM output, in step with p_res_r
  always_comb begin
    res           = p_res_r;
    res.read_data = p_rd_ok_r ? ram_rdata : 8'd0;
  end
  assign res_valid = p_valid_r;

endmodule
`default_nettype wire

// File: src/ubx_fp_outq.sv
// Three-entry result queue decoupling the parser from the output channel.
`timescale 1ns / 1ps
`default_nettype none
module ubx_fp_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire ubx_fp_pkg::ufp_res_t push_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ubx_fp_pkg::ufp_res_t      out_data,
  output logic                      in_ready
);
  import ubx_fp_pkg::*;

  ufp_res_t   q_r [3];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [2:0] credit_used;

  assign out_valid   = cnt_r != 2'd0;
  assign out_data    = q_r[rd_r];
  assign pop         = out_valid && out_ready;
  // an item in the parser's output stage already holds a slot
  assign credit_used = 3'(cnt_r) + 3'(push);
  assign in_ready    = credit_used < 3'd3;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == 2'd2) ? 2'd0 : wr_r + 2'd1;
    end
    if (pop) begin
      rd_nxt = (rd_r == 2'd2) ? 2'd0 : rd_r + 2'd1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: src/ubx_frame_parser.sv
// Top level of the byte-serial binary frame parser.
`timescale 1ns / 1ps
`default_nettype none
// Takes one word per cycle while in_tready is high: a received byte (tuser 0)
// or a read of the payload store (tuser 1). Frames are sync, sync, class, id,
// 16-bit little-endian length, payload, check A, check B; the Fletcher-8 check
// covers class to the end of the payload. Payload bytes go to a BUF_DEPTH-byte
// RAM; a read word returns the byte at read_index, or 0 at or beyond BUF_DEPTH.
// Reads of entries not written since reset return undefined data. One result
// word is produced per good frame, bad check, oversize length or read, passing
// through the parser's output register (beside the RAM read) and the result
// queue. Sustained rate is one word per cycle while out_tready drains results;
// a three-entry queue keeps in_tready high while results wait and drops it only
// when the queue and the parser's output stage together hold three results.
module ubx_frame_parser #(
  parameter int BUF_DEPTH = ubx_fp_pkg::UFP_BUF_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // rx_byte[7:0], read_index[15:8]
  input  wire logic [0:0]  in_tuser,   // kind[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // class_byte[7:0], msg_ident[15:8], frame_length[24:16], read_data[32:25]
  output logic [39:0]      out_tdata,
  output logic [1:0]       out_tuser,  // result_kind[1:0]
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);
  import ubx_fp_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);

  logic          acc;
  logic [7:0]    sync_first_r, sync_first_nxt;
  logic [7:0]    sync_second_r, sync_second_nxt;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          res_valid;
  ufp_res_t      res;
  ufp_res_t      q_data;

  assign acc = in_tvalid && in_tready;

  always_comb begin
    sync_first_nxt  = sync_first_r;
    sync_second_nxt = sync_second_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_nxt  = cfg_wdata;
        CFG_SYNC_SECOND: sync_second_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= UFP_SYNC_FIRST_RST;
      sync_second_r <= UFP_SYNC_SECOND_RST;
    end else begin
      sync_first_r  <= sync_first_nxt;
      sync_second_r <= sync_second_nxt;
    end
  end

  ubx_fp_parser #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .kind       (in_tuser[0]),
    .rx_byte    (in_tdata[7:0]),
    .read_index (in_tdata[15:8]),
    .sync_first (sync_first_r),
    .sync_second(sync_second_r),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  ubx_fp_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ubx_fp_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (q_data),
    .in_ready (in_tready)
  );

  assign out_tuser = q_data.result_kind;
  assign out_tdata = {7'd0, q_data.read_data, q_data.frame_length,
                      q_data.msg_ident, q_data.class_byte};

endmodule
`default_nettype wire

// File: sim/ubx_frame_parser_tb.sv
// Self-checking testbench for the byte-serial binary frame parser.
`timescale 1ns / 1ps
module ubx_frame_parser_tb;
  import ubx_fp_pkg::*;

  localparam int DEPTH = UFP_BUF_DEPTH;

  typedef enum logic [3:0] {
    PH_HUNT1, PH_HUNT2, PH_CLASS, PH_IDENT, PH_LEN_LO, PH_LEN_HI,
    PH_PAYLOAD, PH_CK_A, PH_CK_B
  } rx_phase_t;

  typedef enum int {FLAW_NONE, FLAW_CK_A, FLAW_CK_B, FLAW_CUT} frame_flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // rx_byte[7:0], read_index[15:8]
  logic [0:0]  in_tuser = KIND_RX;  // kind[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // class_byte[7:0], msg_ident[15:8], frame_length[24:16], read_data[32:25]
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;       // result_kind[1:0]
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_SYNC_FIRST;
  logic [7:0]  cfg_wdata = '0;

  ubx_frame_parser #(.BUF_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // parser copy
  logic [7:0]  sync1_val = UFP_SYNC_FIRST_RST;
  logic [7:0]  sync2_val = UFP_SYNC_SECOND_RST;
  rx_phase_t   rx_phase = PH_HUNT1;
  logic [7:0]  frm_class = '0;
  logic [7:0]  frm_ident = '0;
  logic [15:0] frm_len = '0;
  logic [15:0] frm_count = '0;
  logic [7:0]  ck_a = '0;
  logic [7:0]  ck_b = '0;
  logic [7:0]  payload_mem [DEPTH];
  bit [DEPTH-1:0] payload_set = '0;

  ufp_res_t    result_queue[$];

  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned noise_words = 0;
  int unsigned frames_sent = 0;
  int unsigned sync_settings = 1;
  int unsigned kinds_seen [4] = '{0, 0, 0, 0};
  bit          sender_idle = 1'b0;
  bit          recv_idle = 1'b0;
  bit          mix_reads = 1'b0;
  int unsigned stall_left = 0;

  function automatic void add_to_sum(input logic [7:0] b);
    ck_a = ck_a + b;
    ck_b = ck_b + ck_a;
  endfunction

  function automatic bit parse_word(input logic [0:0] kind, input logic [7:0] rxb,
                                    input logic [7:0] idx, output ufp_res_t res);
    res = '0;
    if (kind == KIND_READ) begin
      res.result_kind = RK_READ;
      res.read_data = payload_mem[idx];
      return 1'b1;
    end
    case (rx_phase)
      PH_HUNT2: begin
        if (rxb == sync2_val) rx_phase = PH_CLASS;
        else if (rxb == sync1_val) rx_phase = PH_HUNT2;
        else rx_phase = PH_HUNT1;
      end
      PH_CLASS: begin
        frm_class = rxb;
        ck_a = rxb;
        ck_b = rxb;
        rx_phase = PH_IDENT;
      end
      PH_IDENT: begin
        frm_ident = rxb;
        add_to_sum(rxb);
        rx_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        add_to_sum(rxb);
        frm_len = {8'h00, rxb};
        rx_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        add_to_sum(rxb);
        frm_len[15:8] = rxb;
        frm_count = '0;
        if (frm_len > DEPTH) begin
          frm_len = '0;
          rx_phase = PH_HUNT1;
          res.result_kind = RK_OVERSIZE;
          res.class_byte = frm_class;
          res.msg_ident = frm_ident;
          return 1'b1;
        end
        rx_phase = (frm_len == 0) ? PH_CK_A : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        add_to_sum(rxb);
        if (frm_count < DEPTH) begin
          payload_mem[frm_count[7:0]] = rxb;
          payload_set[frm_count[7:0]] = 1'b1;
        end
        frm_count = frm_count + 16'd1;
        if (frm_count >= frm_len) rx_phase = PH_CK_A;
      end
      PH_CK_A: begin
        if (rxb != ck_a) begin
          rx_phase = PH_HUNT1;
          res.result_kind = RK_BADSUM;
          res.class_byte = frm_class;
          res.msg_ident = frm_ident;
          res.frame_length = frm_len[8:0];
          return 1'b1;
        end
        rx_phase = PH_CK_B;
      end
      PH_CK_B: begin
        rx_phase = PH_HUNT1;
        res.result_kind = (rxb == ck_b) ? RK_GOOD : RK_BADSUM;
        res.class_byte = frm_class;
        res.msg_ident = frm_ident;
        res.frame_length = frm_len[8:0];
        return 1'b1;
      end
      default: rx_phase = (rxb == sync1_val) ? PH_HUNT2 : PH_HUNT1;
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // result side: random back-pressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (recv_idle && $urandom_range(0, 11) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    ufp_res_t got;
    ufp_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.result_kind  = out_tuser;
      got.class_byte   = out_tdata[7:0];
      got.msg_ident    = out_tdata[15:8];
      got.frame_length = out_tdata[24:16];
      got.read_data    = out_tdata[32:25];
      if (result_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", got.result_kind));
      end else begin
        want = result_queue.pop_front();
        kinds_seen[want.result_kind]++;
        if (got.result_kind != want.result_kind)
          report_mismatch($sformatf("result_kind %0d, want %0d",
                                    got.result_kind, want.result_kind));
        if (got.class_byte != want.class_byte)
          report_mismatch($sformatf("class_byte %0d, want %0d",
                                    got.class_byte, want.class_byte));
        if (got.msg_ident != want.msg_ident)
          report_mismatch($sformatf("msg_ident %0d, want %0d",
                                    got.msg_ident, want.msg_ident));
        if (got.frame_length != want.frame_length)
          report_mismatch($sformatf("frame_length %0d, want %0d",
                                    got.frame_length, want.frame_length));
        if (got.read_data != want.read_data)
          report_mismatch($sformatf("read_data %0d, want %0d",
                                    got.read_data, want.read_data));
      end
    end
  end

  task automatic send_word(input logic [0:0] kind, input logic [7:0] rxb,
                           input logic [7:0] idx);
    int unsigned gap;
    ufp_res_t res;
    if (sender_idle && $urandom_range(0, 15) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {idx, rxb};
    in_tuser = kind;
    do @(posedge clk); while (!in_tready);
    if (parse_word(kind, rxb, idx, res)) result_queue.push_back(res);
    words_sent++;
  endtask

  // only entries already written are read back
  task automatic send_read();
    logic [7:0] idx;
    idx = 8'($urandom_range(0, 255));
    while (!payload_set[idx]) idx++;
    send_word(KIND_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] ident,
                            input int unsigned len, input frame_flaw_t flaw);
    logic [7:0] seq[$];
    logic [7:0] sa, sb, b;
    int unsigned keep;
    seq = {sync1_val, sync2_val, cls, ident, len[7:0], len[15:8]};
    sa = '0;
    sb = '0;
    for (int i = 2; i < 6; i++) begin
      sa = sa + seq[i];
      sb = sb + sa;
    end
    if (len <= DEPTH) begin
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        seq.push_back(b);
        sa = sa + b;
        sb = sb + sa;
      end
      if (flaw == FLAW_CK_A) begin
        seq.push_back(sa ^ 8'($urandom_range(1, 255)));
      end else begin
        seq.push_back(sa);
        seq.push_back((flaw == FLAW_CK_B) ? sb ^ 8'($urandom_range(1, 255)) : sb);
      end
    end
    keep = (flaw == FLAW_CUT) ? $urandom_range(1, seq.size() - 1) : seq.size();
    for (int i = 0; i < keep; i++) begin
      if (mix_reads && payload_set != '0 && $urandom_range(0, 15) == 0) send_read();
      send_word(KIND_RX, seq[i], 8'($urandom_range(0, 255)));
    end
    frames_sent++;
  endtask

  task automatic wait_results_in();
    int unsigned guard;
    guard = 0;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (result_queue.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    // a word with no result may still be in the pipeline
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] first, input logic [7:0] second);
    wait_results_in();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_SYNC_FIRST;
    cfg_wdata = first;
    @(negedge clk);
    cfg_index = CFG_SYNC_SECOND;
    cfg_wdata = second;
    @(negedge clk);
    cfg_we = 1'b0;
    sync1_val = first;
    sync2_val = second;
    sync_settings++;
  endtask

  task automatic test_zero_length();
    send_frame(8'h00, 8'hFF, 0, FLAW_NONE);
  endtask

  task automatic test_sync_retest();
    // wrong second sync, then a first sync where the second is due
    send_word(KIND_RX, sync1_val, 8'h00);
    send_word(KIND_RX, 8'h00, 8'hFF);
    send_word(KIND_RX, sync1_val, 8'h00);
    send_frame(8'hFF, 8'h00, 1, FLAW_CK_A);
  endtask

  task automatic test_check_b();
    send_frame(8'h5A, 8'hA5, 0, FLAW_CK_B);
  endtask

  task automatic test_oversize();
    send_frame(8'h01, 8'h02, DEPTH + 1, FLAW_NONE);
  endtask

  task automatic test_full_buffer();
    send_frame(8'hC3, 8'h3C, DEPTH, FLAW_NONE);
    send_word(KIND_READ, 8'hFF, 8'h00);
    send_word(KIND_READ, 8'h00, 8'hFF);
  endtask

  task automatic test_random(input int unsigned n);
    int unsigned start, pick, len, k;
    start = words_sent - noise_words;
    while (words_sent - noise_words - start < n) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(13, DEPTH)
                                          : $urandom_range(0, 12);
      if (pick < 55) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                   FLAW_NONE);
      end else if (pick < 65) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                   FLAW_CK_A);
      end else if (pick < 75) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                   FLAW_CK_B);
      end else if (pick < 80) begin
        len = ($urandom_range(0, 3) == 0) ? DEPTH + 1 : $urandom_range(DEPTH + 2, 65535);
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                   FLAW_NONE);
      end else if (pick < 85) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                   FLAW_CUT);
      end else if (pick < 93) begin
        if (payload_set != '0) send_read();
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) begin
          send_word(KIND_RX, ($urandom_range(0, 3) == 0) ? sync1_val
                                                         : 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
          noise_words++;
        end
      end
    end
  endtask

  initial begin
    logic [7:0] v;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_zero_length();
    test_sync_retest();
    test_check_b();
    test_oversize();
    test_full_buffer();

    sender_idle = 1'b1;
    recv_idle = 1'b1;
    mix_reads = 1'b1;
    test_random(40);
    write_sync(8'h00, 8'hFF);
    test_random(40);
    write_sync(8'hFF, 8'h00);
    test_random(40);
    v = 8'($urandom_range(0, 255));
    write_sync(v, v);
    test_random(20);
    wait_results_in();
    test_random(20);
    write_sync(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    sender_idle = 1'b0;
    recv_idle = 1'b0;
    test_random(40);

    wait_results_in();
    repeat (10) @(posedge clk);
    if (result_queue.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", result_queue.size()));
    $display("%0d words in %0d frames plus %0d noise bytes, %0d sync settings",
             words_sent, frames_sent, noise_words, sync_settings);
    $display("results: %0d good, %0d bad check, %0d oversize, %0d reads",
             kinds_seen[RK_GOOD], kinds_seen[RK_BADSUM], kinds_seen[RK_OVERSIZE],
             kinds_seen[RK_READ]);
    if (errors == 0) begin
      $display("PASS ubx_frame_parser");
    end else begin
      $display("FAIL ubx_frame_parser");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout");
    $display("FAIL ubx_frame_parser");
    $finish;
  end

endmodule

// File: ubx_frame_parser.f
src/ubx_fp_pkg.sv
src/ubx_fp_ram.sv
src/ubx_fp_parser.sv
src/ubx_fp_outq.sv
src/ubx_frame_parser.sv
sim/ubx_frame_parser_tb.sv
